@@ rtl/vie_pkg.sv @@
// Package for the variable-length quantity encoder.
// Holds the group geometry constants and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package vie_pkg;

    // One output group carries seven payload bits.
    localparam int GROUP_BITS = 7;
    // A full 64-bit value needs at most ten groups.
    localparam int MAX_GROUPS = 10;
    // Width of the extended value, split into groups.
    localparam int EXT_BITS   = GROUP_BITS * MAX_GROUPS;
    // Width of the group index.
    localparam int IDX_BITS   = $clog2(MAX_GROUPS);
    // Width of the input word on the channel.
    localparam int IN_BITS    = 64;

    // Flag bit that marks every byte except the last one.
    localparam logic [7:0] CONT_FLAG = 8'h80;

    typedef logic [MAX_GROUPS-1:0][GROUP_BITS-1:0] t_groups;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/vie_if.sv @@
// Channel interfaces for the variable-length quantity encoder.
// vie_in_if carries one input integer, vie_out_if one encoded byte.
// Depends on vie_pkg for the input width.
`timescale 1ns / 1ps

interface vie_in_if;
    logic                       valid;
    logic                       ready;
    logic [vie_pkg::IN_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface vie_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/vlq_integer_encoder_core.sv @@
// Top level of the variable-length quantity encoder.
// Depends on vie_pkg and on the channel interfaces in vie_if.sv.
//
// Usage:
//   i_in carries one integer per transaction; only its low VALUE_WIDTH bits
//   are used. They are sign-extended when signed mode is set, otherwise
//   zero-extended. o_out delivers the encoding, one byte per transaction,
//   most significant 7-bit group first; last marks the final byte, whose
//   bit 7 is clear. i_cfg_we writes i_cfg_wdata into the signed mode bit;
//   write it only while the block is idle.
// Sequence:
//   The idle state takes the value; ready is high only in idle. The scan
//   state then finds the group count, each step one 7-bit shift and zero
//   compare on a single shared shifter; a ten-group run needs no final
//   compare. The emit state then loads the bytes into the output register,
//   pausing while the receiver stalls, and returns to idle after the last
//   byte, so no new integer is taken before that byte is loaded.
// Reset:
//   Reset empties the output register, returns the sequencer to idle and
//   sets signed mode. A stalled receiver holds the current byte in the
//   output register and pauses the emit sequence; no byte is dropped.
`timescale 1ns / 1ps

module vlq_integer_encoder_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    vie_in_if.sink    i_in,
    vie_out_if.source o_out
);
    import vie_pkg::*;

    // Configuration and sequencer state.
    logic                r_signed_mode;
    t_state              r_state;
    t_state              n_state;
    logic [IDX_BITS-1:0] r_k;
    logic [IDX_BITS-1:0] n_k;

    // Datapath registers.
    t_groups             r_grp;
    logic [IN_BITS-1:0]  r_scan;
    logic                r_o_valid;
    logic [7:0]          r_o_byte;
    logic                r_o_last;

    // Combinational helpers.
    logic                fill;
    logic [EXT_BITS-1:0] ext;
    logic [IN_BITS-1:0]  scan_init;
    logic                accept;
    logic                load_out;
    logic                scan_zero;
    logic [GROUP_BITS-1:0] grp_sel;

    // Extend the low VALUE_WIDTH bits to the full group width.
    assign fill = r_signed_mode & i_in.value[VALUE_WIDTH-1];
    always_comb begin
        for (int b = 0; b < EXT_BITS; b++) begin
            if (b < VALUE_WIDTH) begin
                ext[b] = i_in.value[b];
            end else begin
                ext[b] = fill;
            end
        end
    end

    // The scan starts on the bits above the first group: in signed mode the
    // inverted value for negatives, shifted by six so the sign bit counts.
    always_comb begin
        if (r_signed_mode) begin
            if (fill) begin
                scan_init = {6'b0, ~ext[IN_BITS-1:6]};
            end else begin
                scan_init = {6'b0, ext[IN_BITS-1:6]};
            end
        end else begin
            scan_init = {7'b0, ext[IN_BITS-1:7]};
        end
    end

    assign accept    = i_in.valid && i_in.ready;
    assign scan_zero = (r_scan == '0);
    assign load_out  = (r_state == ST_EMIT) && (!r_o_valid || o_out.ready);
    assign grp_sel   = r_grp[r_k];

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                    n_k     = '0;
                end
            end
            ST_SCAN: begin
                if (scan_zero) begin
                    n_state = ST_EMIT;
                end else if (r_k == IDX_BITS'(MAX_GROUPS - 2)) begin
                    n_state = ST_EMIT;
                    n_k     = r_k + 1'b1;
                end else begin
                    n_k     = r_k + 1'b1;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    if (r_k == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_k           <= '0;
            r_signed_mode <= 1'b1;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_signed_mode <= i_cfg_wdata;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Value, scan shifter and output byte registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp  <= t_groups'(ext);
            r_scan <= scan_init;
        end else if (r_state == ST_SCAN) begin
            r_scan <= r_scan >> GROUP_BITS;
        end
        if (load_out) begin
            r_o_byte <= (r_k != '0) ? (CONT_FLAG | {1'b0, grp_sel}) : {1'b0, grp_sel};
            r_o_last <= (r_k == '0);
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.out_byte = r_o_byte;
    assign o_out.last     = r_o_last;

    // The continuation flag is set on exactly the bytes that are not last.
    a_flag_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.out_byte[7] == !o_out.last))
        else $error("continuation flag disagrees with last");

    // The group index never exceeds the largest group.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= IDX_BITS'(MAX_GROUPS - 1))
        else $error("group index out of range");

    // An accepted transaction always starts the length scan.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SCAN))
        else $error("accepted value did not start the scan");

    // A byte that is not last is followed by more bytes of the same value.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_k != '0) |=> (r_state == ST_EMIT))
        else $error("emit sequence ended early");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for vlq_integer_encoder_core: a directed table, then random integers.
// Every output byte is checked against expected bytes from the directed table or a local VLQ encoder.
// Depends on vie_pkg (rtl/vie_pkg.sv) and the channel interfaces (rtl/vie_if.sv).
`timescale 1ns / 1ps

module testbench;

    import vie_pkg::*;

    localparam int VALUE_WIDTH  = 64;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 75;
    localparam int BURST_ITEMS  = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_ROWS     = 22;

    typedef logic [IN_BITS-1:0] t_value;

    localparam t_value VALUE_MASK = {IN_BITS{1'b1}} >> (IN_BITS - VALUE_WIDTH);

    // Signed mode settings, named so that the table reads clearly.
    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    // One expected output byte.
    typedef struct packed {
        logic [7:0] enc_byte;
        logic       last;
    } t_vlq_byte;

    // One row of the directed table. A row with nbytes of zero is checked
    // against the encoder model; otherwise bytes holds the encoding,
    // left-aligned with the first byte in the top eight bits.
    typedef struct {
        logic        mode;
        t_value      value;
        int          nbytes;
        logic [79:0] bytes;
    } t_vlq_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    vie_in_if  in_ch ();
    vie_out_if out_ch ();

    vlq_integer_encoder_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Model copy of the signed mode register and the bytes still owed by the block.
    logic      mode_signed;
    t_vlq_byte pending_bytes[$];
    int        err_count;
    int        cycle_count;

    // Idling controls, written by the stimulus process at phase boundaries.
    int tx_gap_pct;
    int rx_stall_pct;
    int rx_hold_req;

    t_vlq_row dir_rows[NUM_ROWS];

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter that ends a hung run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Encode one integer as VLQ bytes and queue them as expected output.
    function automatic void encode_vlq(input t_value raw);
        t_value    v;
        t_value    mag;
        t_value    grp_src;
        logic      neg;
        int        n;
        int        i;
        int        k;
        t_vlq_byte e;
        v   = raw & VALUE_MASK;
        neg = mode_signed && v[VALUE_WIDTH-1];
        if (neg) begin
            v = v | ~VALUE_MASK;
        end
        mag = neg ? ~v : v;
        // Shortest run of groups that holds the value; in signed mode the
        // leading group must also carry the sign at bit 6.
        n = 1;
        while (n < MAX_GROUPS &&
               (mode_signed ? ((mag >> (GROUP_BITS * n - 1)) != 0)
                            : ((v >> (GROUP_BITS * n)) != 0))) begin
            n++;
        end
        for (i = 0; i < n; i++) begin
            k = n - 1 - i;
            if (neg) begin
                grp_src = t_value'($signed(v) >>> (GROUP_BITS * k));
            end else begin
                grp_src = v >> (GROUP_BITS * k);
            end
            e.enc_byte = {(i != n - 1), grp_src[GROUP_BITS-1:0]};
            e.last     = (i == n - 1);
            pending_bytes.push_back(e);
        end
    endfunction

    // Random integer whose encoding length is spread over the whole range.
    function automatic t_value pick_value();
        t_value v;
        int     w;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: v = '0;
                    1: v = '1;
                    2: v = {1'b1, {(IN_BITS-1){1'b0}}};
                    default: v = {1'b0, {(IN_BITS-1){1'b1}}};
                endcase
            end
            1: ;
            default: begin
                w = $urandom_range(1, IN_BITS);
                if (w < IN_BITS) begin
                    v = v & ((t_value'(1) << w) - 1);
                end
                if ($urandom_range(1)) begin
                    v = ~v;
                end
            end
        endcase
        return v;
    endfunction

    // Offer one integer and return at the edge where the transaction completes.
    task automatic offer_value(input t_value val);
        if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= {$urandom, $urandom};
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < tx_gap_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= val;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    // Stop offering and wait until every expected byte has been taken.
    task automatic drain_output();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the signed mode register; only called while the block is idle.
    task automatic write_mode(input logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_signed = m;
    endtask

    // Receiver: checks each output transaction and drives ready.
    initial begin : receiver
        int        hold_left;
        int        hold_ack;
        t_vlq_byte want;
        hold_left    = 0;
        hold_ack     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_bytes.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("Unexpected byte %h last %b", out_ch.out_byte, out_ch.last);
                    end
                end else begin
                    want = pending_bytes.pop_front();
                    if (out_ch.out_byte !== want.enc_byte || out_ch.last !== want.last) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("Byte mismatch: expected %h last %b, got %h last %b",
                                     want.enc_byte, want.last, out_ch.out_byte, out_ch.last);
                        end
                    end
                end
            end
            // A new hold request starts a long hold-off that fills the block.
            if (rx_hold_req != hold_ack) begin
                hold_ack  = rx_hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases.
    initial begin : stimulus
        t_vlq_byte e;
        t_value    val;
        int        r;
        int        i;
        int        ph;

        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        i_rst_n      = 1'b0;
        err_count    = 0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 0;
        mode_signed  = MODE_SIGNED;

        dir_rows = '{
            // Signed mode straight after reset: zero, edges of one and two groups.
            '{MODE_SIGNED,   64'h0,                   1, {8'h00, 72'h0}},
            '{MODE_SIGNED,   64'h3F,                  1, {8'h3F, 72'h0}},
            '{MODE_SIGNED,   64'h40,                  2, {16'h8040, 64'h0}},
            '{MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, 1, {8'h7F, 72'h0}},
            '{MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FFC0, 1, {8'h40, 72'h0}},
            '{MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FFBF, 2, {16'hFF3F, 64'h0}},
            // Full-width extremes need ten groups.
            '{MODE_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, 10, 80'h80FF_FFFF_FFFF_FFFF_FF7F},
            '{MODE_SIGNED,   64'h8000_0000_0000_0000, 10, 80'hFF80_8080_8080_8080_8000},
            // 32-bit values arriving sign-extended, and a mixed pattern.
            '{MODE_SIGNED,   64'hFFFF_FFFF_8000_0000, 0, 80'h0},
            '{MODE_SIGNED,   64'h0000_0000_7FFF_FFFF, 0, 80'h0},
            '{MODE_SIGNED,   64'h0123_4567_89AB_CDEF, 0, 80'h0},
            // Unsigned mode.
            '{MODE_UNSIGNED, 64'h0,                   1, {8'h00, 72'h0}},
            '{MODE_UNSIGNED, 64'h7F,                  1, {8'h7F, 72'h0}},
            '{MODE_UNSIGNED, 64'h80,                  2, {16'h8100, 64'h0}},
            '{MODE_UNSIGNED, 64'h3FFF,                2, {16'hFF7F, 64'h0}},
            '{MODE_UNSIGNED, 64'h4000,                3, {24'h818000, 56'h0}},
            '{MODE_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 10, 80'h81FF_FFFF_FFFF_FFFF_FF7F},
            '{MODE_UNSIGNED, 64'h8000_0000_0000_0000, 10, 80'h8180_8080_8080_8080_8000},
            // 32-bit value arriving zero-extended, and a mixed pattern.
            '{MODE_UNSIGNED, 64'h0000_0000_FFFF_FFFF, 0, 80'h0},
            '{MODE_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA, 0, 80'h0},
            // Back to signed mode.
            '{MODE_SIGNED,   64'h5555_5555_5555_5555, 0, 80'h0},
            '{MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FF80, 2, {16'hFF00, 64'h0}}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; a change of mode waits for the block to go idle.
        for (r = 0; r < NUM_ROWS; r++) begin
            if (dir_rows[r].mode != mode_signed) begin
                drain_output();
                write_mode(dir_rows[r].mode);
            end
            offer_value(dir_rows[r].value);
            if (dir_rows[r].nbytes == 0) begin
                encode_vlq(dir_rows[r].value);
            end else begin
                for (i = 0; i < dir_rows[r].nbytes; i++) begin
                    e.enc_byte = dir_rows[r].bytes[79 - 8 * i -: 8];
                    e.last     = (i == dir_rows[r].nbytes - 1);
                    pending_bytes.push_back(e);
                end
            end
        end
        drain_output();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_gap_pct   <= 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_gap_pct   <= 65;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_gap_pct   <= 0;
                    rx_stall_pct <= 65;
                end
                default: begin
                    tx_gap_pct   <= 8;
                    rx_stall_pct <= 8;
                end
            endcase
            write_mode(ph[0] ? MODE_SIGNED : MODE_UNSIGNED);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                val = pick_value();
                offer_value(val);
                encode_vlq(val);
            end
            drain_output();
        end

        // Long receiver hold-off while the sender keeps offering back to back.
        tx_gap_pct   <= 0;
        rx_stall_pct <= 0;
        rx_hold_req  <= rx_hold_req + 1;
        write_mode(1'($urandom_range(1)));
        for (i = 0; i < BURST_ITEMS; i++) begin
            val = pick_value();
            offer_value(val);
            encode_vlq(val);
        end
        drain_output();

        // Let any stray bytes show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && pending_bytes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/vie_pkg.sv
rtl/vie_if.sv
rtl/vlq_integer_encoder_core.sv
dv/testbench.sv
